// ----- hdl/pesh_pkg.sv -----
package pesh_pkg;

    localparam int TS_BYTES = 5;
    localparam int TS_BITS  = 33;
    localparam int IDX_W    = 3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PREFIX = 2'd1;
    localparam logic [1:0] ST_MARKER = 2'd2;
    localparam logic [1:0] ST_SHORT  = 2'd3;

    // header bytes needed by the time stamps
    localparam logic [7:0] NEED_PTS     = 8'(TS_BYTES);
    localparam logic [7:0] NEED_PTS_DTS = 8'(2 * TS_BYTES);

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LEN    = 7'b0000010,
        PH_FLAGS  = 7'b0000100,
        PH_HDRLEN = 7'b0001000,
        PH_PTS    = 7'b0010000,
        PH_DTS    = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]         pes_id;
        logic [15:0]        packet_length;
        logic [15:0]        flags;
        logic [7:0]         header_length;
        logic [TS_BITS-1:0] pts;
        logic [TS_BITS-1:0] dts;
        logic [1:0]         status;
    } t_result;

endpackage

// ----- hdl/pes_header_parser.sv -----
// PES header parser.
// Input channel (i_valid / o_ready): one stream byte per request. A byte
// with i_start_req high is the stream identifier byte and restarts the parse;
// bytes outside a header without i_start_req are dropped.
// Output channel (o_valid / i_ready): one result per complete header, with
// stream identifier, packet length, flag fields, header length, 33-bit PTS and
// DTS (zero when absent) and a status code that keeps the first error seen.
// Latency: with the output free, the result is valid the cycle after the
// byte that ends the header (header length byte, last time stamp byte or
// last skipped byte).
// Throughput: one byte per cycle while o_ready is high; every byte is handled
// by the per-byte field logic in front of the result register.
// Stall: bytes are still taken while a result waits for i_ready. A second
// header that ends meanwhile is parked in a spare result register and
// o_ready (registered) drops until the receiver takes the first.
// Reset (synchronous, active low) returns the parser to idle, waiting for a
// start byte, and drops any pending result.
module pes_header_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_start_req,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_pes_id,
    output logic [15:0]               o_packet_length,
    output logic [1:0]                o_scrambling,
    output logic [3:0]                o_basic_flags,
    output logic [1:0]                o_time_flags,
    output logic [5:0]                o_optional_flags,
    output logic [7:0]                o_header_length,
    output logic [pesh_pkg::TS_BITS-1:0] o_pts,
    output logic [pesh_pkg::TS_BITS-1:0] o_dts,
    output logic [1:0]                o_status
);
    import pesh_pkg::*;

    localparam logic [IDX_W-1:0] TS_LAST = IDX_W'(TS_BYTES - 1);

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_skip, n_skip;
    logic [7:0]         r_id, n_id;
    logic [15:0]        r_len, n_len;
    logic [15:0]        r_flags, n_flags;
    logic [7:0]         r_hdr_len, n_hdr_len;
    logic [TS_BITS-1:0] r_pts, n_pts;
    logic [TS_BITS-1:0] r_dts, n_dts;
    logic [1:0]         r_error, n_error;
    logic               r_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               in_acc;
    logic               out_free;
    logic               emit;
    t_result            res_new;
    logic [TS_BITS-1:0] ts_cur, ts_new;
    logic               ts_marker_bad;
    logic [7:0]         needed;
    logic [1:0]         err_code;
    logic               err_hit;

    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_valid || i_ready;

    // time stamp byte assembly; the bit 0 split is folded into the 33-bit value
    always_comb begin
        ts_cur        = (r_phase == PH_DTS) ? r_dts : r_pts;
        ts_marker_bad = 1'b0;
        case (r_idx)
            3'd0: begin
                ts_new        = {i_data_byte[3:1], 30'b0};
                ts_marker_bad = !i_data_byte[0];
            end
            3'd1: ts_new = ts_cur | {3'b0, i_data_byte, 22'b0};
            3'd2: begin
                ts_new        = ts_cur | {11'b0, i_data_byte[7:1], 15'b0};
                ts_marker_bad = !i_data_byte[0];
            end
            3'd3: ts_new = ts_cur | {18'b0, i_data_byte, 7'b0};
            default: begin
                ts_new        = ts_cur | {26'b0, i_data_byte[7:1]};
                ts_marker_bad = !i_data_byte[0];
            end
        endcase
    end

    always_comb begin
        needed = r_flags[7] ? (r_flags[6] ? NEED_PTS_DTS : NEED_PTS) : 8'd0;
    end

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_skip    = r_skip;
        n_id      = r_id;
        n_len     = r_len;
        n_flags   = r_flags;
        n_hdr_len = r_hdr_len;
        n_pts     = r_pts;
        n_dts     = r_dts;
        n_error   = r_error;
        emit      = 1'b0;
        err_hit   = 1'b0;
        err_code  = ST_OK;

        if (in_acc) begin
            if (i_start_req) begin
                n_phase   = PH_LEN;
                n_idx     = '0;
                n_skip    = '0;
                n_id      = i_data_byte;
                n_len     = '0;
                n_flags   = '0;
                n_hdr_len = '0;
                n_pts     = '0;
                n_dts     = '0;
                n_error   = ST_OK;
            end else begin
                case (r_phase)
                    PH_LEN: begin
                        n_len = {r_len[7:0], i_data_byte};
                        n_idx = r_idx + 1'b1;
                        if (r_idx != '0) begin
                            n_idx   = '0;
                            n_phase = PH_FLAGS;
                        end
                    end
                    PH_FLAGS: begin
                        if (r_idx == '0 && i_data_byte[7:6] != 2'b10) begin
                            err_hit  = 1'b1;
                            err_code = ST_PREFIX;
                        end
                        n_flags = {r_flags[7:0], i_data_byte};
                        n_idx   = r_idx + 1'b1;
                        if (r_idx != '0) begin
                            n_idx   = '0;
                            n_phase = PH_HDRLEN;
                        end
                    end
                    PH_HDRLEN: begin
                        n_hdr_len = i_data_byte;
                        n_idx     = '0;
                        if (i_data_byte < needed) begin
                            err_hit  = 1'b1;
                            err_code = ST_SHORT;
                            n_skip   = '0;
                        end else begin
                            n_skip = i_data_byte - needed;
                        end
                        if (r_flags[7]) begin
                            n_phase = PH_PTS;
                        end else if (n_skip == '0) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_PTS, PH_DTS: begin
                        if (r_phase == PH_DTS) begin
                            n_dts = ts_new;
                        end else begin
                            n_pts = ts_new;
                        end
                        err_hit  = ts_marker_bad;
                        err_code = ST_MARKER;
                        n_idx    = r_idx + 1'b1;
                        if (r_idx == TS_LAST) begin
                            n_idx = '0;
                            if (r_phase == PH_PTS && r_flags[6]) begin
                                n_phase = PH_DTS;
                            end else if (r_skip == '0) begin
                                emit = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (r_skip != '0) begin
                            n_skip = r_skip - 1'b1;
                        end
                        if (n_skip == '0) begin
                            emit = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // first error in stream order wins
                if (err_hit && r_error == ST_OK) begin
                    n_error = err_code;
                end
                if (emit) begin
                    n_phase = PH_IDLE;
                    n_idx   = '0;
                end
            end
        end
    end

    always_comb begin
        res_new.pes_id        = n_id;
        res_new.packet_length = n_len;
        res_new.flags         = n_flags;
        res_new.header_length = n_hdr_len;
        res_new.pts           = n_pts;
        res_new.dts           = n_dts;
        res_new.status        = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_idx        <= '0;
            r_skip       <= '0;
            r_error      <= ST_OK;
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
            r_error <= n_error;
            // no header can end while a result is parked (o_ready is low)
            if (out_free) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= emit;
                end
            end else if (emit) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_len     <= n_len;
        r_flags   <= n_flags;
        r_hdr_len <= n_hdr_len;
        r_pts     <= n_pts;
        r_dts     <= n_dts;
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (emit) begin
                r_out <= res_new;
            end
        end else if (emit) begin
            r_skid <= res_new;
        end
    end

    assign o_valid          = r_valid;
    assign o_pes_id         = r_out.pes_id;
    assign o_packet_length  = r_out.packet_length;
    assign o_scrambling     = r_out.flags[13:12];
    assign o_basic_flags    = r_out.flags[11:8];
    assign o_time_flags     = r_out.flags[7:6];
    assign o_optional_flags = r_out.flags[5:0];
    assign o_header_length  = r_out.header_length;
    assign o_pts            = r_out.pts;
    assign o_dts            = r_out.dts;
    assign o_status         = r_out.status;

endmodule

// ----- hdl/pesh_chk.sv -----
module pesh_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         i_start_req,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [7:0]                   o_header_length,
    input  logic [1:0]                   o_time_flags,
    input  logic [pesh_pkg::TS_BITS-1:0] o_pts,
    input  logic [pesh_pkg::TS_BITS-1:0] o_dts,
    input  logic [1:0]                   o_status
);
    import pesh_pkg::*;

    // a stalled result stays up with its status unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pts))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a start byte taken while the output drains never ends a header
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_start_req && (!o_valid || i_ready) |=> !o_valid)
        else $error("result after start byte");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SHORT |->
            o_time_flags[1] && o_header_length < NEED_PTS_DTS)
        else $error("short header status without time stamps");

    a_no_ts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_time_flags[0] |-> o_dts == '0)
        else $error("DTS set without DTS flag");

endmodule

bind pes_header_parser pesh_chk u_pesh_chk (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import pesh_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_byte_req;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [7:0]          i_data_byte = 8'd0;
    logic                i_start_req = 1'b0;
    logic                i_ready = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [7:0]          o_pes_id;
    logic [15:0]         o_packet_length;
    logic [1:0]          o_scrambling;
    logic [3:0]          o_basic_flags;
    logic [1:0]          o_time_flags;
    logic [5:0]          o_optional_flags;
    logic [7:0]          o_header_length;
    logic [TS_BITS-1:0]  o_pts;
    logic [TS_BITS-1:0]  o_dts;
    logic [1:0]          o_status;

    pes_header_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_start_req      (i_start_req),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pes_id         (o_pes_id),
        .o_packet_length  (o_packet_length),
        .o_scrambling     (o_scrambling),
        .o_basic_flags    (o_basic_flags),
        .o_time_flags     (o_time_flags),
        .o_optional_flags (o_optional_flags),
        .o_header_length  (o_header_length),
        .o_pts            (o_pts),
        .o_dts            (o_dts),
        .o_status         (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_byte_req pending_bytes [$];
    t_result   expected_headers [$];

    int items_queued = 0;
    int bytes_taken = 0;
    int headers_seen = 0;
    int headers_flagged = 0;
    int mismatches = 0;
    logic tail_quiet = 1'b0;

    // parser shadow state
    t_phase             ps_phase;
    logic [IDX_W-1:0]   ps_idx;
    logic [7:0]         ps_skip;
    logic [7:0]         ps_id;
    logic [15:0]        ps_len;
    logic [15:0]        ps_flags;
    logic [7:0]         ps_hdr_len;
    logic [TS_BITS-1:0] ps_pts;
    logic [TS_BITS-1:0] ps_dts;
    logic [1:0]         ps_status;

    task clear_parse();
        ps_phase   = PH_IDLE;
        ps_idx     = '0;
        ps_skip    = '0;
        ps_id      = '0;
        ps_len     = '0;
        ps_flags   = '0;
        ps_hdr_len = '0;
        ps_pts     = '0;
        ps_dts     = '0;
        ps_status  = ST_OK;
    endtask

    task flag_error(input logic [1:0] code);
        if (ps_status == ST_OK) begin
            ps_status = code;
        end
    endtask

    task add_ts_byte(inout logic [TS_BITS-1:0] acc, input logic [7:0] b,
                     input logic [IDX_W-1:0] idx);
        case (idx)
            3'd0: acc = 33'(b[3:1]) << 30;
            3'd1: acc = acc | (33'(b) << 22);
            3'd2: acc = acc | (33'(b[7:1]) << 15);
            3'd3: acc = acc | (33'(b) << 7);
            default: acc = acc | 33'(b[7:1]);
        endcase
        if (!idx[0] && !b[0]) begin
            flag_error(ST_MARKER);
        end
    endtask

    task report_header();
        t_result res;
        res.pes_id        = ps_id;
        res.packet_length = ps_len;
        res.flags         = ps_flags;
        res.header_length = ps_hdr_len;
        res.pts           = ps_pts;
        res.dts           = ps_dts;
        res.status        = ps_status;
        expected_headers.push_back(res);
        ps_phase = PH_IDLE;
        ps_idx   = '0;
    endtask

    task finish_or_skip();
        if (ps_skip == 8'd0) begin
            report_header();
        end else begin
            ps_phase = PH_SKIP;
        end
    endtask

    task parse_pes_byte(input logic [7:0] b, input logic start);
        logic [1:0] tf;
        logic [7:0] need;
        if (start) begin
            clear_parse();
            ps_id    = b;
            ps_phase = PH_LEN;
        end else begin
            case (ps_phase)
                PH_LEN: begin
                    ps_len = {ps_len[7:0], b};
                    ps_idx = ps_idx + 1'b1;
                    if (ps_idx >= 2) begin
                        ps_idx   = '0;
                        ps_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    if (ps_idx == 0 && b[7:6] != 2'b10) begin
                        flag_error(ST_PREFIX);
                    end
                    ps_flags = {ps_flags[7:0], b};
                    ps_idx   = ps_idx + 1'b1;
                    if (ps_idx >= 2) begin
                        ps_idx   = '0;
                        ps_phase = PH_HDRLEN;
                    end
                end
                PH_HDRLEN: begin
                    ps_hdr_len = b;
                    tf   = ps_flags[7:6];
                    need = tf[1] ? (tf[0] ? NEED_PTS_DTS : NEED_PTS) : 8'd0;
                    if (b < need) begin
                        flag_error(ST_SHORT);
                        ps_skip = '0;
                    end else begin
                        ps_skip = b - need;
                    end
                    ps_idx = '0;
                    if (tf[1]) begin
                        ps_phase = PH_PTS;
                    end else begin
                        finish_or_skip();
                    end
                end
                PH_PTS, PH_DTS: begin
                    if (ps_phase == PH_PTS) begin
                        add_ts_byte(ps_pts, b, ps_idx);
                    end else begin
                        add_ts_byte(ps_dts, b, ps_idx);
                    end
                    ps_idx = ps_idx + 1'b1;
                    if (ps_idx >= TS_BYTES) begin
                        ps_idx = '0;
                        if (ps_phase == PH_PTS && ps_flags[6]) begin
                            ps_phase = PH_DTS;
                        end else begin
                            finish_or_skip();
                        end
                    end
                end
                PH_SKIP: begin
                    if (ps_skip > 0) begin
                        ps_skip = ps_skip - 1'b1;
                    end
                    if (ps_skip == 0) begin
                        report_header();
                    end
                end
                default: ;
            endcase
        end
    endtask

    task check_field(input string name, input logic [63:0] exp_v, input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
        end
    endtask

    // monitor: check the delivered header, then shadow-parse the byte taken
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
        end else begin
            if (o_valid && i_ready) begin
                headers_seen++;
                if (o_status != ST_OK) begin
                    headers_flagged++;
                end
                if (expected_headers.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected header, expected none, got id 0x%0h status %0d",
                             $time, o_pes_id, o_status);
                end else begin
                    want = expected_headers.pop_front();
                    check_field("pes_id", 64'(want.pes_id), 64'(o_pes_id));
                    check_field("packet_length", 64'(want.packet_length),
                                64'(o_packet_length));
                    check_field("scrambling", 64'(want.flags[13:12]), 64'(o_scrambling));
                    check_field("basic_flags", 64'(want.flags[11:8]), 64'(o_basic_flags));
                    check_field("time_flags", 64'(want.flags[7:6]), 64'(o_time_flags));
                    check_field("optional_flags", 64'(want.flags[5:0]),
                                64'(o_optional_flags));
                    check_field("header_length", 64'(want.header_length),
                                64'(o_header_length));
                    check_field("pts", 64'(want.pts), 64'(o_pts));
                    check_field("dts", 64'(want.dts), 64'(o_dts));
                    check_field("status", 64'(want.status), 64'(o_status));
                end
            end
            if (i_valid && o_ready) begin
                parse_pes_byte(i_data_byte, i_start_req);
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // byte driver
    int tx_gap = 0;
    int tx_calm = 0;

    always @(posedge i_clk) begin
        t_byte_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
            tx_calm <= 0;
        end else begin
            tail_quiet <= pending_bytes.size() < 60;
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!tail_quiet && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
                    i_valid <= 1'b0;
                    tx_gap  <= $urandom_range(0, 10);
                end else begin
                    req = pending_bytes.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= req.data;
                    i_start_req <= req.start;
                    if (tx_calm > 0) begin
                        tx_calm <= tx_calm - 1;
                    end else if ($urandom_range(0, 40) == 0) begin
                        tx_calm <= $urandom_range(20, 80);
                    end
                end
            end
        end
    end

    // result receiver, with one long hold-off to back the parser up
    int rx_gap = 0;
    int rx_calm = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rx_gap    <= 0;
            rx_calm   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_taken >= 150) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (!tail_quiet && rx_calm == 0 && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            rx_gap  <= $urandom_range(0, 10);
        end else begin
            i_ready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm <= rx_calm - 1;
            end else if ($urandom_range(0, 50) == 0) begin
                rx_calm <= $urandom_range(20, 100);
            end
        end
    end

    // bad_mark picks one marker bit to clear (0..5), cut > 0 truncates the header
    task automatic queue_header(input logic [7:0] sid, input logic [15:0] plen,
                                input logic [7:0] fl1, input logic [7:0] fl2,
                                input logic [7:0] hlen, input logic [32:0] pts_v,
                                input logic [32:0] dts_v, input int bad_mark,
                                input int cut);
        logic [7:0] hdr [$];
        logic [32:0] tsv;
        int n_ts;
        int n_skip;
        hdr = {sid, plen[15:8], plen[7:0], fl1, fl2, hlen};
        n_ts = fl2[7] ? (fl2[6] ? 2 : 1) : 0;
        for (int k = 0; k < n_ts; k++) begin
            tsv = (k == 0) ? pts_v : dts_v;
            hdr.push_back({4'($urandom_range(0, 15)), tsv[32:30], bad_mark != 3 * k});
            hdr.push_back(tsv[29:22]);
            hdr.push_back({tsv[21:15], bad_mark != 3 * k + 1});
            hdr.push_back(tsv[14:7]);
            hdr.push_back({tsv[6:0], bad_mark != 3 * k + 2});
        end
        n_skip = (hlen >= TS_BYTES * n_ts) ? hlen - TS_BYTES * n_ts : 0;
        repeat (n_skip) hdr.push_back(8'($urandom));
        if (cut > 0 && cut < hdr.size()) begin
            hdr = hdr[0:cut-1];
        end
        foreach (hdr[k]) begin
            pending_bytes.push_back('{data: hdr[k], start: (k == 0)});
        end
        items_queued += hdr.size();
    endtask

    task automatic queue_noise(input int n, input logic with_start);
        repeat (n) begin
            pending_bytes.push_back('{data: 8'($urandom),
                                      start: with_start && $urandom_range(0, 3) == 0});
        end
        if (with_start) begin
            items_queued += n;
        end
    endtask

    initial begin
        int pick;
        int need;
        int hsel;
        logic [1:0] tf;
        logic [7:0] hlen;
        logic [7:0] fl1;

        // directed: idle bytes, field extremes, every error and restart case
        pending_bytes.push_back('{data: 8'h00, start: 1'b0});
        pending_bytes.push_back('{data: 8'hFF, start: 1'b0});
        queue_header(8'hFF, 16'hFFFF, 8'hBF, 8'h3F, 8'd0, '0, '0, -1, 0);
        queue_header(8'hE0, 16'h1234, 8'h80, 8'hC0, 8'd10, '0, '0, -1, 3);
        queue_header(8'h00, 16'h0000, 8'h80, 8'h40, 8'd0, '0, '0, -1, 0);
        queue_header(8'hC0, 16'h8001, 8'h80, 8'hC0, 8'd10, {33{1'b1}}, '0, -1, 0);
        queue_header(8'hBD, 16'h00FF, 8'h00, 8'h80, 8'd2, 33'h1_5555_5555, '0, 2, 0);
        queue_header(8'hE1, 16'h0100, 8'hA5, 8'hC1, 8'd3, 33'h0_AAAA_AAAA,
                     33'h1_0000_0001, 3, 0);
        queue_header(8'hBE, 16'h0007, 8'h80, 8'h01, 8'd3, '0, '0, -1, 0);

        // random: mostly well-formed headers, some noise and broken ones
        while (items_queued < 400) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                queue_noise($urandom_range(1, 3), 1'b0);
            end else if (pick == 1) begin
                queue_noise($urandom_range(1, 8), 1'b1);
            end else begin
                pick = $urandom_range(0, 5);
                tf   = (pick >= 4) ? 2'd3 : (pick >= 2) ? 2'd2 : 2'(pick);
                need = tf[1] ? (tf[0] ? 2 * TS_BYTES : TS_BYTES) : 0;
                hsel = $urandom_range(0, 39);
                if (hsel == 0) begin
                    hlen = 8'($urandom_range(0, 255));
                end else if (hsel < 4 && need > 0) begin
                    hlen = 8'($urandom_range(0, need - 1));
                end else begin
                    hlen = 8'(need + $urandom_range(0, 6));
                end
                fl1 = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : {2'b10, 6'($urandom_range(0, 63))};
                queue_header(8'($urandom), 16'($urandom), fl1,
                             {tf, 6'($urandom_range(0, 63))}, hlen,
                             {1'($urandom_range(0, 1)), 32'($urandom)},
                             {1'($urandom_range(0, 1)), 32'($urandom)},
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : -1,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_headers.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Parsed %0d stream bytes; %0d PES headers reported, %0d of them with an error",
                 bytes_taken, headers_seen, headers_flagged);
        $display("status, including a 300-cycle output hold that backed up the byte input.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
